[rtl/tlvdc_pkg.sv]
// Package for the two-loop vehicle direction counter.
// Holds shared constants, register codes, loop ids and the structs passed between modules.
// No dependencies.
package tlvdc_pkg;

	// default sizes
	localparam int DEF_WINDOW_DEPTH = 10;
	localparam int DEF_FREQ_BITS    = 20;
	localparam int DEF_TIME_BITS    = 48;

	// fixed register and field widths
	localparam int THR_BITS  = 20;
	localparam int SPAN_BITS = 32;
	localparam int CNT_BITS  = 32;
	localparam int CFG_BITS  = 32;
	localparam int IDX_BITS  = 3;

	// quotient bits resolved per divider stage
	localparam int DIV_STEP = 4;

	// register reset values
	localparam logic [THR_BITS-1:0]  THR_RST   = THR_BITS'(1000);
	localparam logic [SPAN_BITS-1:0] STALE_RST = SPAN_BITS'(2000000);
	localparam logic [SPAN_BITS-1:0] LOCK_RST  = SPAN_BITS'(5000000);

	// configuration register index
	typedef enum logic [IDX_BITS-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_STALE     = 3'd1,
		REG_LOCKOUT   = 3'd2,
		REG_ENTRANCE  = 3'd3,
		REG_START     = 3'd4
	} reg_idx_t;

	// loop that raised the last recorded event
	typedef enum logic [1:0] {
		LOOP_A    = 2'd0,
		LOOP_B    = 2'd1,
		LOOP_NONE = 2'd2
	} loop_id_t;

	// timing and direction settings seen by the event merge
	typedef struct packed {
		logic [SPAN_BITS-1:0] stale;
		logic [SPAN_BITS-1:0] lockout;
		logic                 a_entrance;
	} cfg_t;

	// count result of one item
	typedef struct packed {
		logic [CNT_BITS-1:0] count;
		logic                up;
		logic                down;
	} cnt_res_t;

endpackage

[rtl/tlvdc_lane.sv]
// One loop lane: sample ring memory, running sum and event detection.
// Depends on tlvdc_pkg.
module tlvdc_lane
	import tlvdc_pkg::*;
#(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int FREQ_BITS    = DEF_FREQ_BITS,
	parameter int POS_BITS     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
	parameter int SUM_BITS     = FREQ_BITS + $clog2(WINDOW_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [POS_BITS-1:0]  pos,
	input  logic [POS_BITS-1:0]  nxt_pos,
	input  logic                 was_tuned,
	input  logic [FREQ_BITS-1:0] freq,
	input  logic [THR_BITS-1:0]  thr,
	output logic                 ev_s1,
	output logic [SUM_BITS-1:0]  sum_s1
);

	localparam int DB = $clog2(WINDOW_DEPTH + 1);
	localparam int XW = (FREQ_BITS > THR_BITS) ? FREQ_BITS : THR_BITS;
	localparam int PW = XW + DB;

	logic [FREQ_BITS-1:0] ring [WINDOW_DEPTH];
	logic [FREQ_BITS-1:0] rd_q;
	logic [SUM_BITS-1:0]  sum_q;
	logic [SUM_BITS-1:0]  sum_nxt;
	logic [FREQ_BITS-1:0] old;
	logic [XW-1:0]        rise;
	logic [PW-1:0]        prod;
	logic                 ev;

	// entry leaving the ring; unwritten entries read as zero during the fill
	assign old     = was_tuned ? rd_q : '0;
	assign sum_nxt = sum_q - SUM_BITS'(old) + SUM_BITS'(freq);

	// freq > floor(sum/D) + thr  <=>  freq > thr and sum < (freq - thr) * D
	assign rise = XW'(freq) - XW'(thr);
	assign prod = PW'(rise) * PW'(WINDOW_DEPTH);
	assign ev   = was_tuned && (XW'(freq) > XW'(thr)) && (PW'(sum_q) < prod);

	// ring memory, next entry prefetched into rd_q
	always_ff @(posedge clk) begin
		if (accept) begin
			ring[pos] <= freq;
			rd_q      <= (WINDOW_DEPTH == 1) ? freq : ring[nxt_pos];
		end
	end

	// running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			sum_q <= sum_nxt;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1  <= ev;
			sum_s1 <= sum_nxt;
		end
	end

endmodule

[rtl/tlvdc_div.sv]
// Pipelined division of a ring sum by the constant window depth.
// Restoring long division, DIV_STEP quotient bits per stage. Depends on tlvdc_pkg.
module tlvdc_div
	import tlvdc_pkg::*;
#(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int SUM_BITS     = DEF_FREQ_BITS + $clog2(DEF_WINDOW_DEPTH + 1),
	parameter int Q_BITS       = DEF_FREQ_BITS,
	parameter int STAGES       = (SUM_BITS + DIV_STEP - 1) / DIV_STEP
) (
	input  logic                clk,
	input  logic [STAGES-1:0]   ld,
	input  logic [SUM_BITS-1:0] sum_in,
	output logic [Q_BITS-1:0]   quot
);

	localparam int RW = $clog2(WINDOW_DEPTH) + 1;

	logic [RW-1:0]       rem_s [STAGES];
	logic [SUM_BITS-1:0] wrk_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stg
		logic [RW-1:0]       r_in;
		logic [SUM_BITS-1:0] w_in;
		logic [RW-1:0]       r_nx;
		logic [SUM_BITS-1:0] w_nx;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign w_in = sum_in;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign w_in = wrk_s[k-1];
		end

		// shift dividend bits into the remainder, quotient bits into the work word
		always_comb begin
			r_nx = r_in;
			w_nx = w_in;
			for (int j = 0; j < DIV_STEP; j++) begin
				if (k * DIV_STEP + j < SUM_BITS) begin
					r_nx = (r_nx << 1) | RW'(w_nx[SUM_BITS-1]);
					w_nx = w_nx << 1;
					if (r_nx >= RW'(WINDOW_DEPTH)) begin
						r_nx    = r_nx - RW'(WINDOW_DEPTH);
						w_nx[0] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ld[k]) begin
				rem_s[k] <= r_nx;
				wrk_s[k] <= w_nx;
			end
		end
	end

	assign quot = wrk_s[STAGES-1][Q_BITS-1:0];

endmodule

[rtl/tlvdc_merge.sv]
// Event merge: orders the loop events A then B, tracks direction and the net count.
// Depends on tlvdc_pkg.
module tlvdc_merge
	import tlvdc_pkg::*;
#(
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  cfg_t                 cfg,
	input  logic                 cnt_wr,
	input  logic [CNT_BITS-1:0]  cnt_val,
	input  logic                 ev_a,
	input  logic                 ev_b,
	input  logic [TIME_BITS-1:0] t,
	output cnt_res_t             res
);

	loop_id_t             last_q;
	loop_id_t             last_mid;
	logic [TIME_BITS-1:0] ev_time_q;
	logic [TIME_BITS-1:0] chg_time_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [TIME_BITS-1:0] since_ev;
	logic [TIME_BITS-1:0] since_chg;
	logic                 in_stale, past_lock;
	logic                 rel_a, chg_a, rec_a;
	logic                 stale_b, lock_b;
	logic                 rel_b, chg_b, rec_b;

	// time since the last event and the last count change, modulo the time width
	assign since_ev  = t - ev_time_q;
	assign since_chg = t - chg_time_q;
	assign in_stale  = since_ev < TIME_BITS'(cfg.stale);
	assign past_lock = since_chg > TIME_BITS'(cfg.lockout);

	// loop A event
	assign rel_a = ev_a && (last_q != LOOP_A) && in_stale;
	assign chg_a = rel_a && (last_q == LOOP_B) && past_lock;
	assign rec_a = ev_a && (!rel_a || chg_a);

	// loop B event sees the state left by A
	assign last_mid = rec_a ? LOOP_A : last_q;
	assign stale_b  = rec_a ? (cfg.stale != '0) : in_stale;
	assign lock_b   = chg_a ? 1'b0 : past_lock;
	assign rel_b    = ev_b && (last_mid != LOOP_B) && stale_b;
	assign chg_b    = rel_b && (last_mid == LOOP_A) && lock_b;
	assign rec_b    = ev_b && (!rel_b || chg_b);

	// direction and new count
	always_comb begin
		res.up   = (chg_a && !cfg.a_entrance) || (chg_b && cfg.a_entrance);
		res.down = (chg_a && cfg.a_entrance) || (chg_b && !cfg.a_entrance);
		if (res.up) begin
			res.count = cnt_q + CNT_BITS'(1);
		end else if (res.down) begin
			res.count = cnt_q - CNT_BITS'(1);
		end else begin
			res.count = cnt_q;
		end
	end

	// event history and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= LOOP_NONE;
			ev_time_q  <= '0;
			chg_time_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (cnt_wr) begin
				cnt_q <= cnt_val;
			end else if (step) begin
				cnt_q <= res.count;
			end
			if (step) begin
				last_q <= rec_b ? LOOP_B : last_mid;
				if (rec_a || rec_b) begin
					ev_time_q <= t;
				end
				if (chg_a || chg_b) begin
					chg_time_q <= t;
				end
			end
		end
	end

endmodule

[rtl/two_loop_vehicle_direction_counter.sv]
// Top level of the two-loop vehicle direction counter.
// Depends on tlvdc_pkg, tlvdc_lane, tlvdc_div and tlvdc_merge.
//
// Takes one sample item (loop A and loop B frequency plus a microsecond
// timestamp) per clock while s_tready is high and returns one result item
// per sample with the net vehicle count, the up/down and loop event flags,
// both ring baselines and the tuned flag. The first WINDOW_DEPTH samples only
// fill the rings. Each loop has its own lane holding a sample ring and a
// running sum, so the event test and the ring update finish in the accept
// cycle; the merge stage applies both events to the direction state as the
// item leaves stage 1. Throughput is one item per cycle while the output is
// not stalled; the baselines are formed by the pipelined divider that follows
// stage 1. Items move on through empty stages, so input is taken while a
// result waits at the output as long as a stage is free. Configuration writes
// take effect on the next cycle and are meant for idle periods.
module two_loop_vehicle_direction_counter
	import tlvdc_pkg::*;
#(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int FREQ_BITS    = DEF_FREQ_BITS,
	parameter int TIME_BITS    = DEF_TIME_BITS,
	parameter int IN_W         = ((2 * FREQ_BITS + TIME_BITS + 7) / 8) * 8,
	parameter int OUT_W        = ((CNT_BITS + 5 + 2 * FREQ_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// sample items
	input  logic                s_tvalid,
	output logic                s_tready,
	// s_tdata from bit 0: freq_a, freq_b, time_us, zero fill
	input  logic [IN_W-1:0]     s_tdata,
	// result items
	output logic                m_tvalid,
	input  logic                m_tready,
	// m_tdata from bit 0: vehicle_count, counted_up, counted_down, event_a,
	// event_b, baseline_a, baseline_b, tuned, zero fill
	output logic [OUT_W-1:0]    m_tdata,
	// configuration writes
	input  logic                wr_en,
	input  logic [IDX_BITS-1:0] wr_index,
	input  logic [CFG_BITS-1:0] wr_data
);

	localparam int POS_BITS  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_BITS = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_BITS  = FREQ_BITS + FILL_BITS;
	localparam int NDIV      = (SUM_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int L         = NDIV + 1;

	typedef struct packed {
		cnt_res_t cnt;
		logic     ev_a;
		logic     ev_b;
		logic     tuned;
	} res_t;

	// configuration registers
	logic [THR_BITS-1:0]  thr_q;
	logic [SPAN_BITS-1:0] stale_q;
	logic [SPAN_BITS-1:0] lock_q;
	logic                 aent_q;
	logic                 cnt_wr;
	cfg_t                 cfg;

	// pipeline control
	logic [L-1:0]         vld_q;
	logic [L-1:0]         free;
	logic                 accept;

	// fill state
	logic [POS_BITS-1:0]  pos_q;
	logic [POS_BITS-1:0]  nxt_pos;
	logic [FILL_BITS-1:0] fill_q;
	logic                 tuned;
	logic                 tuned_nxt;

	// stage payload
	logic [FREQ_BITS-1:0] freq_a, freq_b;
	logic [TIME_BITS-1:0] time_in;
	logic                 ev_a_s1, ev_b_s1;
	logic [SUM_BITS-1:0]  sum_a_s1, sum_b_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 tuned_s1;
	cnt_res_t             cnt_res;
	res_t                 res_s [1:L-1];
	logic [FREQ_BITS-1:0] mean_a, mean_b;
	logic [FREQ_BITS-1:0] base_a, base_b;
	res_t                 res_out;

	assign freq_a  = s_tdata[FREQ_BITS-1:0];
	assign freq_b  = s_tdata[2*FREQ_BITS-1:FREQ_BITS];
	assign time_in = s_tdata[2*FREQ_BITS+TIME_BITS-1:2*FREQ_BITS];

	// register writes
	assign cnt_wr = wr_en && (wr_index == REG_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RST;
			stale_q <= STALE_RST;
			lock_q  <= LOCK_RST;
			aent_q  <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_THRESHOLD: thr_q   <= wr_data[THR_BITS-1:0];
				REG_STALE:     stale_q <= wr_data[SPAN_BITS-1:0];
				REG_LOCKOUT:   lock_q  <= wr_data[SPAN_BITS-1:0];
				REG_ENTRANCE:  aent_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.stale      = stale_q;
	assign cfg.lockout    = lock_q;
	assign cfg.a_entrance = aent_q;

	// a stage may load when it is empty or its item moves on
	always_comb begin
		free[L-1] = !vld_q[L-1] || m_tready;
		for (int k = L - 2; k >= 0; k--) begin
			free[k] = !vld_q[k] || free[k+1];
		end
	end

	assign s_tready = free[0];
	assign accept   = s_tvalid && free[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (free[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < L; k++) begin
				if (free[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ring position and fill count shared by both lanes
	assign nxt_pos   = (pos_q == POS_BITS'(WINDOW_DEPTH - 1)) ? '0 : pos_q + POS_BITS'(1);
	assign tuned     = (fill_q == FILL_BITS'(WINDOW_DEPTH));
	assign tuned_nxt = tuned || (fill_q == FILL_BITS'(WINDOW_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			pos_q <= nxt_pos;
			if (!tuned) begin
				fill_q <= fill_q + FILL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			time_s1  <= time_in;
			tuned_s1 <= tuned_nxt;
		end
	end

	// loop lanes
	tlvdc_lane #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.FREQ_BITS    (FREQ_BITS),
		.POS_BITS     (POS_BITS),
		.SUM_BITS     (SUM_BITS)
	) u_lane_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pos       (pos_q),
		.nxt_pos   (nxt_pos),
		.was_tuned (tuned),
		.freq      (freq_a),
		.thr       (thr_q),
		.ev_s1     (ev_a_s1),
		.sum_s1    (sum_a_s1)
	);

	tlvdc_lane #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.FREQ_BITS    (FREQ_BITS),
		.POS_BITS     (POS_BITS),
		.SUM_BITS     (SUM_BITS)
	) u_lane_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pos       (pos_q),
		.nxt_pos   (nxt_pos),
		.was_tuned (tuned),
		.freq      (freq_b),
		.thr       (thr_q),
		.ev_s1     (ev_b_s1),
		.sum_s1    (sum_b_s1)
	);

	// event merge, applied as the item leaves stage 1
	tlvdc_merge #(
		.TIME_BITS (TIME_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (vld_q[0] && free[1]),
		.cfg     (cfg),
		.cnt_wr  (cnt_wr),
		.cnt_val (wr_data[CNT_BITS-1:0]),
		.ev_a    (ev_a_s1),
		.ev_b    (ev_b_s1),
		.t       (time_s1),
		.res     (cnt_res)
	);

	// baseline dividers run alongside the result delay line
	tlvdc_div #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SUM_BITS     (SUM_BITS),
		.Q_BITS       (FREQ_BITS),
		.STAGES       (NDIV)
	) u_div_a (
		.clk    (clk),
		.ld     (free[L-1:1]),
		.sum_in (sum_a_s1),
		.quot   (mean_a)
	);

	tlvdc_div #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SUM_BITS     (SUM_BITS),
		.Q_BITS       (FREQ_BITS),
		.STAGES       (NDIV)
	) u_div_b (
		.clk    (clk),
		.ld     (free[L-1:1]),
		.sum_in (sum_b_s1),
		.quot   (mean_b)
	);

	// result delay line
	always_ff @(posedge clk) begin
		if (free[1]) begin
			res_s[1].cnt   <= cnt_res;
			res_s[1].ev_a  <= ev_a_s1;
			res_s[1].ev_b  <= ev_b_s1;
			res_s[1].tuned <= tuned_s1;
		end
		for (int k = 2; k < L; k++) begin
			if (free[k]) begin
				res_s[k] <= res_s[k-1];
			end
		end
	end

	// output item
	assign res_out  = res_s[L-1];
	assign base_a   = res_out.tuned ? mean_a : '0;
	assign base_b   = res_out.tuned ? mean_b : '0;
	assign m_tvalid = vld_q[L-1];
	assign m_tdata  = OUT_W'({res_out.tuned, base_b, base_a, res_out.ev_b, res_out.ev_a,
		res_out.cnt.down, res_out.cnt.up, res_out.cnt.count});

endmodule

[test/tlvdc_checker.sv]
// Checker for the two-loop vehicle direction counter: watches the sample, result and
// configuration ports, predicts every result item and compares it field by field.
// Depends on tlvdc_pkg.
module tlvdc_checker
	import tlvdc_pkg::*;
#(
	parameter int IN_W  = 88,
	parameter int OUT_W = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// s_tdata from bit 0: freq_a, freq_b, time_us, zero fill
	input  logic [IN_W-1:0]     s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// m_tdata from bit 0: vehicle_count, counted_up, counted_down, event_a,
	// event_b, baseline_a, baseline_b, tuned, zero fill
	input  logic [OUT_W-1:0]    m_tdata,
	input  logic                wr_en,
	input  logic [IDX_BITS-1:0] wr_index,
	input  logic [CFG_BITS-1:0] wr_data,
	output int                  mismatch_count,
	output int                  results_owed
);

	localparam int DEPTH = DEF_WINDOW_DEPTH;
	localparam int FW    = DEF_FREQ_BITS;
	localparam int TW    = DEF_TIME_BITS;

	// result field positions in m_tdata
	localparam int UP_BIT     = CNT_BITS;
	localparam int DOWN_BIT   = CNT_BITS + 1;
	localparam int EVA_BIT    = CNT_BITS + 2;
	localparam int EVB_BIT    = CNT_BITS + 3;
	localparam int BASEA_LSB  = CNT_BITS + 4;
	localparam int BASEB_LSB  = BASEA_LSB + FW;
	localparam int TUNED_BIT  = BASEB_LSB + FW;

	typedef struct {
		logic [CNT_BITS-1:0] count;
		logic                up;
		logic                down;
		logic                ev_a;
		logic                ev_b;
		logic [FW-1:0]       base_a;
		logic [FW-1:0]       base_b;
		logic                tuned;
	} window_result_t;

	window_result_t awaited_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int owed = 0;

	assign mismatch_count = mismatches;
	assign results_owed   = owed;

	// predicted block state
	logic [THR_BITS-1:0]  threshold;
	logic [SPAN_BITS-1:0] stale_us;
	logic [SPAN_BITS-1:0] lockout_us;
	logic                 a_entrance;
	logic [FW-1:0]        ring_a [DEPTH];
	logic [FW-1:0]        ring_b [DEPTH];
	logic [31:0]          total_a;
	logic [31:0]          total_b;
	int unsigned          slot;
	int unsigned          filled;
	logic [FW-1:0]        mean_a;
	logic [FW-1:0]        mean_b;
	loop_id_t             last_loop;
	logic [TW-1:0]        last_event_us;
	logic [TW-1:0]        last_change_us;
	logic [CNT_BITS-1:0]  vehicles;

	task automatic clear_state();
		threshold      = THR_RST;
		stale_us       = STALE_RST;
		lockout_us     = LOCK_RST;
		a_entrance     = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			ring_a[i] = '0;
			ring_b[i] = '0;
		end
		total_a        = '0;
		total_b        = '0;
		slot           = 0;
		filled         = 0;
		mean_a         = '0;
		mean_b         = '0;
		last_loop      = LOOP_NONE;
		last_event_us  = '0;
		last_change_us = '0;
		vehicles       = '0;
		awaited_results.delete();
		owed           = 0;
	endtask

	task automatic take_write(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
		case (idx)
			REG_THRESHOLD: threshold  = value[THR_BITS-1:0];
			REG_STALE:     stale_us   = value[SPAN_BITS-1:0];
			REG_LOCKOUT:   lockout_us = value[SPAN_BITS-1:0];
			REG_ENTRANCE:  a_entrance = value[0];
			REG_START:     vehicles   = value[CNT_BITS-1:0];
			default: ;
		endcase
	endtask

	// one loop event against the direction state; +1 up, -1 down, 0 none
	function automatic int apply_event(loop_id_t loop, logic [TW-1:0] t_us);
		logic [TW-1:0] since_event;
		logic [TW-1:0] since_change;
		int dir;
		since_event  = t_us - last_event_us;
		since_change = t_us - last_change_us;
		dir = 0;
		if (loop != last_loop && since_event < TW'(stale_us)) begin
			// related but no partner yet, or still locked out: dropped
			if (last_loop == LOOP_NONE || since_change <= TW'(lockout_us))
				return 0;
			dir = ((loop == LOOP_B) == a_entrance) ? 1 : -1;
			if (dir > 0)
				vehicles = vehicles + 1'b1;
			else
				vehicles = vehicles - 1'b1;
			last_change_us = t_us;
		end
		last_event_us = t_us;
		last_loop     = loop;
		return dir;
	endfunction

	task automatic predict_window(logic [FW-1:0] fa, logic [FW-1:0] fb, logic [TW-1:0] t_us);
		window_result_t r;
		int dir;
		r.up   = 1'b0;
		r.down = 1'b0;
		r.ev_a = 1'b0;
		r.ev_b = 1'b0;
		// events only once the rings are full, against the old means
		if (filled >= DEPTH) begin
			r.ev_a = 64'(fa) > 64'(mean_a) + 64'(threshold);
			r.ev_b = 64'(fb) > 64'(mean_b) + 64'(threshold);
			if (r.ev_a) begin
				dir = apply_event(LOOP_A, t_us);
				if (dir > 0) r.up = 1'b1;
				if (dir < 0) r.down = 1'b1;
			end
			if (r.ev_b) begin
				dir = apply_event(LOOP_B, t_us);
				if (dir > 0) r.up = 1'b1;
				if (dir < 0) r.down = 1'b1;
			end
		end
		// ring insert and running sums
		total_a      = total_a - ring_a[slot] + fa;
		total_b      = total_b - ring_b[slot] + fb;
		ring_a[slot] = fa;
		ring_b[slot] = fb;
		slot         = (slot + 1) % DEPTH;
		if (filled < DEPTH)
			filled++;
		if (filled >= DEPTH) begin
			mean_a = FW'(total_a / DEPTH);
			mean_b = FW'(total_b / DEPTH);
		end
		r.count  = vehicles;
		r.base_a = mean_a;
		r.base_b = mean_b;
		r.tuned  = filled >= DEPTH;
		awaited_results.push_back(r);
		owed = awaited_results.size();
	endtask

	task automatic report_mismatch(string what);
		mismatches++;
		$display("%0t: result %0d: %s", $time, results_seen, what);
	endtask

	task automatic check_field(string name, longint got, longint want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	task automatic compare_result(logic [OUT_W-1:0] word);
		window_result_t w;
		if (awaited_results.size() == 0) begin
			report_mismatch("result item with nothing outstanding");
		end else begin
			w = awaited_results.pop_front();
			owed = awaited_results.size();
			check_field("vehicle_count", longint'($signed(word[CNT_BITS-1:0])),
				longint'($signed(w.count)));
			check_field("counted_up", word[UP_BIT], w.up);
			check_field("counted_down", word[DOWN_BIT], w.down);
			check_field("event_a", word[EVA_BIT], w.ev_a);
			check_field("event_b", word[EVB_BIT], w.ev_b);
			check_field("baseline_a", word[BASEA_LSB +: FW], w.base_a);
			check_field("baseline_b", word[BASEB_LSB +: FW], w.base_b);
			check_field("tuned", word[TUNED_BIT], w.tuned);
		end
		results_seen++;
	endtask

	// results are compared before the same-edge sample is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (m_tvalid && m_tready)
				compare_result(m_tdata);
			if (wr_en)
				take_write(wr_index, wr_data);
			if (s_tvalid && s_tready)
				predict_window(s_tdata[0 +: FW], s_tdata[FW +: FW], s_tdata[2*FW +: TW]);
		end
	end

endmodule

[test/testbench.sv]
// Top of the testbench for the two-loop vehicle direction counter: clock, reset,
// sample and configuration stimulus, result back-pressure, watchdog and verdict.
// Depends on tlvdc_pkg, two_loop_vehicle_direction_counter and tlvdc_checker.
module testbench
	import tlvdc_pkg::*;
();

	localparam int FW           = DEF_FREQ_BITS;
	localparam int TW           = DEF_TIME_BITS;
	localparam int IN_W         = ((2 * FW + TW + 7) / 8) * 8;
	localparam int OUT_W        = ((CNT_BITS + 5 + 2 * FW + 7) / 8) * 8;
	localparam logic [FW-1:0] FREQ_MAX = '1;
	localparam logic [TW-1:0] TIME_MAX = '1;
	localparam logic [FW-1:0] CALM_HZ  = FW'(100000);
	localparam logic [FW-1:0] SPIKE_HZ = FW'(400000);
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 204;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic [IN_W-1:0]     s_tdata  = '0;
	logic                m_tready = 1'b0;
	logic                wr_en    = 1'b0;
	logic [IDX_BITS-1:0] wr_index = '0;
	logic [CFG_BITS-1:0] wr_data  = '0;
	wire                 s_tready;
	wire                 m_tvalid;
	wire  [OUT_W-1:0]    m_tdata;
	int                  mismatch_count;
	int                  results_owed;

	// traffic state
	bit                   tx_burst = 1'b0;
	bit                   rx_burst = 1'b0;
	int                   rx_hold  = 0;
	int                   idle_cycles = 0;
	int                   items_sent  = 0;
	logic [TW-1:0]        now_us   = '0;
	logic [FW-1:0]        calm_a   = CALM_HZ;
	logic [FW-1:0]        calm_b   = CALM_HZ;
	logic [THR_BITS-1:0]  cur_thr  = THR_RST;
	logic [SPAN_BITS-1:0] cur_stale = STALE_RST;

	two_loop_vehicle_direction_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	tlvdc_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: random stall after each accepted item, none during a receive burst
	always @(posedge clk or negedge arst_n) begin
		int stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold  <= 0;
		end else if (m_tvalid && m_tready) begin
			stall = rx_burst ? 0 : $urandom_range(0, 3);
			m_tready <= (stall == 0);
			rx_hold  <= (stall > 0) ? stall - 1 : 0;
		end else if (rx_hold != 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("two_loop_vehicle_direction_counter: mismatch");
			$finish;
		end
	end

	// valid stays high across back-to-back items
	task automatic send_sample(logic [FW-1:0] fa, logic [FW-1:0] fb, logic [TW-1:0] t_us);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= IN_W'({t_us, fb, fa});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (results_owed != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// writes every register, spare bits random, then one unused index
	task automatic write_config(logic [THR_BITS-1:0] thr, logic [SPAN_BITS-1:0] stale,
		logic [SPAN_BITS-1:0] lockout, logic entrance, logic [CNT_BITS-1:0] start);
		wr_en    <= 1'b1;
		wr_index <= REG_THRESHOLD;
		wr_data  <= {(CFG_BITS - THR_BITS)'($urandom), thr};
		@(posedge clk);
		wr_index <= REG_STALE;
		wr_data  <= stale;
		@(posedge clk);
		wr_index <= REG_LOCKOUT;
		wr_data  <= lockout;
		@(posedge clk);
		wr_index <= REG_ENTRANCE;
		wr_data  <= {(CFG_BITS - 1)'($urandom), entrance};
		@(posedge clk);
		wr_index <= REG_START;
		wr_data  <= start;
		@(posedge clk);
		wr_index <= IDX_BITS'($urandom_range(int'(REG_START) + 1, (1 << IDX_BITS) - 1));
		wr_data  <= $urandom;
		@(posedge clk);
		wr_en    <= 1'b0;
		@(posedge clk);
		cur_thr   = thr;
		cur_stale = stale;
	endtask

	function automatic logic [FW-1:0] clamp_hz(longint hz);
		return (hz > longint'(FREQ_MAX)) ? FREQ_MAX : FW'(hz);
	endfunction

	// quiet loop reading near its resting level
	function automatic logic [FW-1:0] calm(logic [FW-1:0] rest);
		return clamp_hz(longint'(rest) + $urandom_range(0, 300));
	endfunction

	// loop reading meant to clear the threshold, sometimes only just
	function automatic logic [FW-1:0] raised(logic [FW-1:0] rest);
		longint hz;
		hz = longint'(rest) + longint'(cur_thr);
		if ($urandom_range(0, 3) == 0)
			hz = hz + $urandom_range(0, 2);
		else
			hz = hz + longint'(cur_thr / 2) + $urandom_range(1, 60000);
		return clamp_hz(hz);
	endfunction

	// timestamp steps scaled to the stale window, rare big jumps and rewinds
	task automatic step_clock();
		int unsigned span;
		int unsigned pick;
		span = (cur_stale > 32'd4000000) ? 32'd4000000 : cur_stale;
		if (span < 1000)
			span = 1000;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			now_us = now_us + $urandom_range(0, span / 2);
		else if (pick < 88)
			now_us = now_us + $urandom_range(0, 3 * span);
		else if (pick < 97)
			now_us = now_us + $urandom;
		else
			now_us = TW'({$urandom, $urandom});
	endtask

	task automatic emit(logic [FW-1:0] fa, logic [FW-1:0] fb);
		step_clock();
		send_sample(fa, fb, now_us);
		items_sent++;
		if (items_sent % 40 == 0) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst <= ($urandom_range(0, 3) == 0);
		end
	endtask

	// a vehicle crossing: lead loop, maybe a quiet gap, then trail loop
	task automatic crossing();
		bit lead_a;
		bit overlap;
		lead_a = $urandom_range(0, 1);
		repeat ($urandom_range(1, 2))
			emit(lead_a ? raised(calm_a) : calm(calm_a), lead_a ? calm(calm_b) : raised(calm_b));
		repeat ($urandom_range(0, 2))
			emit(calm(calm_a), calm(calm_b));
		repeat ($urandom_range(1, 2)) begin
			overlap = ($urandom_range(0, 4) == 0);
			emit((!lead_a || overlap) ? raised(calm_a) : calm(calm_a),
				(lead_a || overlap) ? raised(calm_b) : calm(calm_b));
		end
	endtask

	initial begin
		int pick;
		int target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tuning fill at reset settings, field extremes inside it
		send_sample(CALM_HZ, CALM_HZ, '0);
		send_sample(CALM_HZ, CALM_HZ, TW'(100000));
		send_sample('0, FREQ_MAX, TW'(200000));
		send_sample(FREQ_MAX, '0, TW'(300000));
		for (int i = 4; i < DEF_WINDOW_DEPTH; i++)
			send_sample(CALM_HZ, CALM_HZ, TW'(i * 100000));

		// first event with no partner, then A then B counts up
		send_sample(CALM_HZ, CALM_HZ, TW'(10000000));
		send_sample(SPIKE_HZ, CALM_HZ, TW'(10100000));
		send_sample(CALM_HZ, SPIKE_HZ, TW'(10600000));
		// related event inside the lockout is dropped
		send_sample(SPIKE_HZ, CALM_HZ, TW'(10900000));
		// both loops in one sample: A recorded, B completes a crossing
		send_sample(SPIKE_HZ, SPIKE_HZ, TW'(16000000));
		send_sample(CALM_HZ, CALM_HZ, TW'(16500000));
		// B then A counts down
		send_sample(CALM_HZ, SPIKE_HZ, TW'(25000000));
		send_sample(SPIKE_HZ, CALM_HZ, TW'(25500000));
		// timestamp at its top, then wrapping back to zero
		send_sample(FREQ_MAX, CALM_HZ, TIME_MAX);
		send_sample(CALM_HZ, FREQ_MAX, '0);
		send_sample(CALM_HZ, CALM_HZ, TW'(1000));
		now_us = TW'(1000);

		// random phases, each behind a full drain and a new setting
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
				0: write_config('0, '1, '0, 1'b0, 32'h8000_0000);
				1: write_config('1, '0, '1, 1'b1, 32'h7fff_ffff);
				2: write_config(THR_BITS'($urandom_range(500, 20000)), STALE_RST,
					SPAN_BITS'($urandom_range(0, 3000000)), 1'b1, 32'h7fff_fff0);
				default: write_config(THR_BITS'($urandom_range(0, 100000)),
					SPAN_BITS'($urandom_range(100000, 5000000)),
					SPAN_BITS'($urandom_range(0, 6000000)), 1'($urandom), $urandom);
			endcase
			calm_a = FW'($urandom_range(0, int'(FREQ_MAX) / 2));
			calm_b = FW'($urandom_range(0, int'(FREQ_MAX) / 2));
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					crossing();
				else if (pick < 80)
					emit(calm(calm_a), calm(calm_b));
				else if (pick < 90)
					emit(raised(calm_a), raised(calm_b));
				else
					emit(FW'($urandom), FW'($urandom));
			end
		end

		drain_results();
		if (mismatch_count == 0 && results_owed == 0)
			$display("two_loop_vehicle_direction_counter: match");
		else
			$display("two_loop_vehicle_direction_counter: mismatch");
		$finish;
	end

endmodule
